>>> hdl/nsva_pkg.sv
`default_nettype none
package nsva_pkg;
  typedef enum logic [1:0] {
    FUNC_LAMP   = 2'd0,
    FUNC_LISTEN = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_START = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_STOP,
    ST_START,
    ST_EMIT
  } state_t;

  localparam int unsigned COORD_W  = 20;
  localparam int unsigned DIST_W   = 45;
  localparam int unsigned RADIUS_W = 12;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned LAMP_W   = 8;
  localparam int unsigned SLOT_W   = 3;
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 12'd360;
  localparam logic CFG_RADIUS = 1'b0;
  localparam logic CFG_COUNT  = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } pos_t;
endpackage
`default_nettype wire

>>> hdl/nsva_dist.sv
`default_nettype none
// Pipelined squared distance: lamp position against one listener per cycle.
module nsva_dist (
  input  wire logic          clk,
  input  wire nsva_pkg::pos_t a,
  input  wire nsva_pkg::pos_t b,
  output logic [nsva_pkg::DIST_W-1:0] dist_r
);
  logic [nsva_pkg::COORD_W:0] dx_r, dy_r, dz_r;
  logic [2*nsva_pkg::COORD_W+1:0] mx_r, my_r, mz_r;
  logic signed [nsva_pkg::COORD_W:0] ex, ey, ez;

  always_comb begin
    ex = {a.x[nsva_pkg::COORD_W-1], a.x} - {b.x[nsva_pkg::COORD_W-1], b.x};
    ey = {a.y[nsva_pkg::COORD_W-1], a.y} - {b.y[nsva_pkg::COORD_W-1], b.y};
    ez = {a.z[nsva_pkg::COORD_W-1], a.z} - {b.z[nsva_pkg::COORD_W-1], b.z};
  end

  always_ff @(posedge clk) begin
    dx_r <= ex[nsva_pkg::COORD_W] ? -ex : ex;
    dy_r <= ey[nsva_pkg::COORD_W] ? -ey : ey;
    dz_r <= ez[nsva_pkg::COORD_W] ? -ez : ez;
    mx_r <= dx_r * dx_r;
    my_r <= dy_r * dy_r;
    mz_r <= dz_r * dz_r;
    dist_r <= nsva_pkg::DIST_W'(mx_r) + nsva_pkg::DIST_W'(my_r)
            + nsva_pkg::DIST_W'(mz_r);
  end
endmodule
`default_nettype wire

>>> hdl/nearest_source_voice_allocator.sv
`default_nettype none
// Voice allocator for the nearest lamps. Lamp and listener writes can follow
// back to back while idle. A tick holds off the input until its last result has
// gone. It reads each scanned lamp position from the lamp memory once per
// listener and feeds a pipelined distance unit. A qualifying lamp goes into the
// sorted wanted list in the cycle its last listener completes. Scanning steps
// through lamp_count lamps (capped at MAX_LAMPS), each against every listener.
// Stopping visits each slot in turn, then starting goes through the wanted
// lamps in turn. The results give one entry per slot. Unused slots report lamp 0.
module nearest_source_voice_allocator #(
  parameter int unsigned MAX_LAMPS     = 256,
  parameter int unsigned MAX_LISTENERS = 4,
  parameter int unsigned SLOTS         = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic [1:0] in_func,
  input  wire logic [7:0] in_entry_index,
  input  wire logic signed [19:0] in_pos_x,
  input  wire logic signed [19:0] in_pos_y,
  input  wire logic signed [19:0] in_pos_z,
  input  wire logic in_present,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic [2:0] out_slot,
  output logic [7:0] out_lamp,
  output logic       out_occupied,
  output logic [1:0] out_action,
  output logic       out_last,
  input  wire logic  cfg_valid,
  output logic       cfg_ready,
  input  wire logic  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int unsigned LA_W = (MAX_LAMPS > 1) ? $clog2(MAX_LAMPS) : 1;
  localparam int unsigned LI_W = (MAX_LISTENERS > 1) ? $clog2(MAX_LISTENERS) : 1;
  localparam int unsigned SL_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CN_W = $clog2(SLOTS + 1);
  localparam int unsigned SC_W = $clog2(MAX_LAMPS + 1);
  localparam int unsigned PIPE = 4;

  nsva_pkg::state_t state_r, state_nxt;
  logic [nsva_pkg::RADIUS_W-1:0] radius_r;
  logic [nsva_pkg::COUNT_W-1:0]  count_r;

  nsva_pkg::pos_t lamp_mem [MAX_LAMPS];
  nsva_pkg::pos_t lamp_rd_r;
  nsva_pkg::pos_t lis_r [MAX_LISTENERS];
  logic [MAX_LISTENERS-1:0] lis_on_r;

  logic [7:0] slot_lamp_r [SLOTS];
  logic [SLOTS-1:0] busy_r;
  logic [1:0] act_r [SLOTS];
  logic [7:0] want_idx_r [SLOTS];
  logic [nsva_pkg::DIST_W-1:0] want_d_r [SLOTS];
  logic [CN_W-1:0] nwant_r;

  logic [SC_W-1:0] scan_n;
  logic [SC_W-1:0] lamp_r;
  logic [LI_W-1:0] lis_r_i;
  logic [SC_W-1:0] tag_n_r [PIPE];
  logic [PIPE-1:0] tag_v_r;
  logic [LI_W-1:0] tag_j_r [PIPE];
  logic [nsva_pkg::DIST_W-1:0] dist_d, best_r, best_cur, limit;
  logic issue_done_r;
  logic [SL_W-1:0] s_r;
  logic [CN_W-1:0] w_r;
  logic [7:0] lamp_o_r;
  logic occ_o_r, last_o_r;
  logic [1:0] act_o_r;
  logic [SL_W-1:0] slot_o_r;
  logic out_v_r;

  assign limit = nsva_pkg::DIST_W'({{nsva_pkg::RADIUS_W{1'b0}}, radius_r}
                                   * {{nsva_pkg::RADIUS_W{1'b0}}, radius_r});
  assign scan_n = (32'(count_r) > MAX_LAMPS) ? SC_W'(MAX_LAMPS) : SC_W'(count_r);
  assign in_ready  = (state_r == nsva_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  nsva_dist u_dist (.clk(clk), .a(lamp_rd_r), .b(lis_r[tag_j_r[0]]), .dist_r(dist_d));

  // minimum over listeners of the lamp in the last stage
  assign best_cur = (tag_j_r[PIPE-1] == '0) ? limit : best_r;

  logic [nsva_pkg::DIST_W-1:0] dmin;
  logic lamp_end;
  always_comb begin
    dmin = best_cur;
    if (lis_on_r[tag_j_r[PIPE-1]] && dist_d < dmin) dmin = dist_d;
    lamp_end = tag_v_r[PIPE-1] && tag_j_r[PIPE-1] == LI_W'(MAX_LISTENERS - 1);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nsva_pkg::ST_IDLE:
        if (in_valid && in_func == nsva_pkg::FUNC_TICK) state_nxt = nsva_pkg::ST_SCAN;
      nsva_pkg::ST_SCAN:
        if (issue_done_r && tag_v_r == '0) state_nxt = nsva_pkg::ST_STOP;
      nsva_pkg::ST_STOP:
        if (s_r == SL_W'(SLOTS - 1)) state_nxt = nsva_pkg::ST_START;
      nsva_pkg::ST_START:
        if (w_r >= nwant_r) state_nxt = nsva_pkg::ST_EMIT;
      nsva_pkg::ST_EMIT:
        if (out_v_r && out_ready && last_o_r) state_nxt = nsva_pkg::ST_IDLE;
      default: state_nxt = nsva_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= nsva_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  // lamp memory with one registered read port
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_func == nsva_pkg::FUNC_LAMP
        && 32'(in_entry_index) < MAX_LAMPS)
      lamp_mem[LA_W'(in_entry_index)] <= '{in_pos_x, in_pos_y, in_pos_z};
    lamp_rd_r <= lamp_mem[LA_W'(lamp_r)];
  end

  // tags: stage 0 aligns with lamp_rd_r
  logic issue;
  assign issue = (state_r == nsva_pkg::ST_SCAN) && !issue_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= nsva_pkg::RADIUS_RST;
      count_r  <= '0;
      lis_on_r <= '0;
      busy_r   <= '0;
      tag_v_r  <= '0;
      out_v_r  <= 1'b0;
      issue_done_r <= 1'b0;
      for (int i = 0; i < MAX_LISTENERS; i++) lis_r[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == nsva_pkg::CFG_RADIUS) radius_r <= cfg_data[nsva_pkg::RADIUS_W-1:0];
        else count_r <= cfg_data[nsva_pkg::COUNT_W-1:0];
      end
      if (in_valid && in_ready && in_func == nsva_pkg::FUNC_LISTEN
          && 32'(in_entry_index) < MAX_LISTENERS) begin
        lis_r[LI_W'(in_entry_index)]    <= '{in_pos_x, in_pos_y, in_pos_z};
        lis_on_r[LI_W'(in_entry_index)] <= in_present;
      end
      tag_v_r <= {tag_v_r[PIPE-2:0], issue && lamp_r < scan_n};
      for (int k = 1; k < PIPE; k++) begin
        tag_n_r[k] <= tag_n_r[k-1];
        tag_j_r[k] <= tag_j_r[k-1];
      end
      tag_n_r[0] <= lamp_r;
      tag_j_r[0] <= lis_r_i;
      case (state_r)
        nsva_pkg::ST_IDLE: begin
          lamp_r <= '0;
          lis_r_i <= '0;
          issue_done_r <= 1'b0;
          nwant_r <= '0;
          s_r <= '0;
          w_r <= '0;
          for (int s = 0; s < SLOTS; s++) act_r[s] <= nsva_pkg::ACT_NONE;
        end
        nsva_pkg::ST_SCAN: begin
          if (issue) begin
            if (lamp_r >= scan_n) issue_done_r <= 1'b1;
            else if (lis_r_i == LI_W'(MAX_LISTENERS - 1)) begin
              lis_r_i <= '0;
              lamp_r <= lamp_r + 1'b1;
            end else lis_r_i <= lis_r_i + 1'b1;
          end
          if (tag_v_r[PIPE-1]) best_r <= dmin;
          if (lamp_end && dmin < limit
              && !(nwant_r == CN_W'(SLOTS) && dmin >= want_d_r[SLOTS-1])) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (32'(i) < 32'(nwant_r) && want_d_r[i] > dmin) begin
                if (i + 1 < SLOTS) begin
                  want_d_r[i+1] <= want_d_r[i];
                  want_idx_r[i+1] <= want_idx_r[i];
                end
              end
              if ((i == 0 || !(32'(i) - 1 < 32'(nwant_r) && want_d_r[i-1] > dmin))
                  && (32'(i) >= 32'(nwant_r) || want_d_r[i] > dmin)
                  && (i == 0 || want_d_r[i-1] <= dmin || 32'(i) - 1 >= 32'(nwant_r))
                  && 32'(i) <= 32'(nwant_r)) begin
                want_d_r[i] <= dmin;
                want_idx_r[i] <= 8'(tag_n_r[PIPE-1]);
              end
            end
            if (nwant_r < CN_W'(SLOTS)) nwant_r <= nwant_r + 1'b1;
          end
        end
        nsva_pkg::ST_STOP: begin
          if (busy_r[s_r]) begin
            logic keep;
            keep = 1'b0;
            for (int i = 0; i < SLOTS; i++)
              if (32'(i) < 32'(nwant_r) && want_idx_r[i] == slot_lamp_r[s_r]) keep = 1'b1;
            if (!keep) begin
              busy_r[s_r] <= 1'b0;
              act_r[s_r] <= nsva_pkg::ACT_STOP;
            end
          end
          s_r <= s_r + 1'b1;
        end
        nsva_pkg::ST_START: begin
          if (w_r < nwant_r) begin
            logic held, found;
            logic [SL_W-1:0] fs;
            held = 1'b0;
            found = 1'b0;
            fs = '0;
            for (int s = 0; s < SLOTS; s++)
              if (busy_r[s] && slot_lamp_r[s] == want_idx_r[SL_W'(w_r)]) held = 1'b1;
            for (int s = SLOTS - 1; s >= 0; s--)
              if (!busy_r[s]) begin
                found = 1'b1;
                fs = SL_W'(s);
              end
            if (!held && found) begin
              busy_r[fs] <= 1'b1;
              slot_lamp_r[fs] <= want_idx_r[SL_W'(w_r)];
              act_r[fs] <= nsva_pkg::ACT_START;
            end
            w_r <= (!held && !found) ? nwant_r : w_r + 1'b1;
          end
          s_r <= '0;
        end
        nsva_pkg::ST_EMIT: begin
          if (!out_v_r || out_ready) begin
            if (out_v_r && last_o_r) out_v_r <= 1'b0;
            else begin
              out_v_r  <= 1'b1;
              slot_o_r <= s_r;
              occ_o_r  <= busy_r[s_r];
              lamp_o_r <= busy_r[s_r] ? slot_lamp_r[s_r] : 8'd0;
              act_o_r  <= act_r[s_r];
              last_o_r <= (s_r == SL_W'(SLOTS - 1));
              s_r <= s_r + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid    = out_v_r;
  assign out_slot     = 3'(slot_o_r);
  assign out_lamp     = lamp_o_r;
  assign out_occupied = occ_o_r;
  assign out_action   = act_o_r;
  assign out_last     = last_o_r;

  a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == nsva_pkg::ST_EMIT) else $error("result outside emit");
  a_nwant_max: assert property (@(posedge clk) disable iff (!rst_n)
    nwant_r <= CN_W'(SLOTS)) else $error("wanted count overflow");
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while emitting");
endmodule
`default_nettype wire
